// File: hw/rtl/pulse_capture_stats_unit_macros.svh
// ----------------------------------------------------------------------------
// pulse capture stats assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PULSE_CAPTURE_STATS_UNIT_MACROS_SVH
`define PULSE_CAPTURE_STATS_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define PCS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcs assertion failed");

// next-cycle implication, checked out of reset
`define PCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcs assertion failed");

`else

`define PCS_ASSERT_IMPL(label, ante, cons)
`define PCS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// shared types and constants of the pulse capture stats unit
// ----------------------------------------------------------------------------
package pcs_pkg;

    // timestamp and result widths fixed by the interface
    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 15;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS      = 1'd1;

    // register reset values
    localparam logic              PULSE_MODE_RESET = 1'b1;
    localparam logic [TIME_W-1:0] TICKS_RESET      = 32'd1000000;

    // percent in q8: 100 * 256
    localparam logic [DUTY_W-1:0] DUTY_SCALE = 15'd25600;

    // status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } pcs_div_status_t;

endpackage

// File: hw/rtl/pcs_div.sv
// ----------------------------------------------------------------------------
// pcs_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pcs_div
    import pcs_pkg::*;
#(
    parameter int N_W = 47,
    parameter int D_W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [N_W-1:0]        dividend,
    input  logic [D_W-1:0]        divisor,
    output logic [N_W-1:0]        quotient,
    output pcs_div_status_t       status
);

    localparam int STEP_W = $clog2(N_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [N_W-1:0]    quot_reg;
    logic [D_W-1:0]    rem_reg;
    logic [D_W-1:0]    dvsr_reg;

    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              fits;
    logic [D_W-1:0]    rem_next;
    logic [N_W-1:0]    quot_next;

    // shift in the next dividend bit and try the subtract
    assign trial     = {rem_reg, quot_reg[N_W-1]};
    assign diff      = trial - {1'b0, dvsr_reg};
    assign fits      = trial >= {1'b0, dvsr_reg};
    assign rem_next  = fits ? diff[D_W-1:0] : trial[D_W-1:0];
    assign quot_next = {quot_reg[N_W-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(N_W);
                quot_reg <= dividend;
                rem_reg  <= '0;
                dvsr_reg <= divisor;
            end else if (busy_reg) begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: hw/rtl/pulse_capture_stats_unit.sv
// ----------------------------------------------------------------------------
// pulse_capture_stats_unit
// max, average, period, frequency and duty over one capture of power samples
// ----------------------------------------------------------------------------
// Each input transfer carries one signed power sample with its timestamp;
// tlast closes the capture. A sample that does not close the capture is
// folded into the running max, sum, count and level-change tracking in the
// cycle it is taken, so such samples stream at one per cycle. The closing
// sample starts a short sequencer around one shared restoring divider (one
// quotient bit per cycle over N = max(SAMPLE_BITS + count bits, 47) bits):
// average, then ticks_per_second / period, then high time * 25600 / period.
// Without a valid pulse only the average is divided. The input is not ready
// while the sequencer runs. Results sit in an output register, so samples
// of the next capture are taken while the last result waits for m_tready.
// pulse_mode is sampled when the capture closes; level changes are tracked
// in both modes. Samples beyond MAX_SAMPLES are ignored except for tlast.
// Configuration writes are meant for idle periods only.
// ----------------------------------------------------------------------------
`include "pulse_capture_stats_unit_macros.svh"

module pulse_capture_stats_unit
    import pcs_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // sample input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample_power, sample_time (from bit 0 up), zero padded
    input  logic [((SAMPLE_BITS + TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                  s_tlast,

    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // max_power, avg_power, period_ticks, freq_hz, duty_q8 (from bit 0 up), zero padded
    output logic [((2 * SAMPLE_BITS + 2 * TIME_W + DUTY_W + 7) / 8) * 8 - 1:0] m_tdata,
    // pulse_valid
    output logic [0:0]            m_tuser
);

    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W     = SAMPLE_BITS + CNT_W;
    localparam int PROD_W    = TIME_W + DUTY_W;
    localparam int DIV_N_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DIV_D_W   = (CNT_W > TIME_W) ? CNT_W : TIME_W;
    localparam int OUT_W     = 2 * SAMPLE_BITS + 2 * TIME_W + DUTY_W;
    localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8 - OUT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_AVG,
        S_FREQ,
        S_DUTY,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic              pulse_mode_reg;
    logic [TIME_W-1:0] ticks_reg;

    // capture state
    logic signed [SAMPLE_BITS-1:0] running_max_reg;
    logic [SUM_W-1:0]              running_sum_reg;
    logic [CNT_W-1:0]              sample_count_reg;
    logic                          start_high_reg;
    logic [1:0]                    edge_stage_reg;
    logic [TIME_W-1:0]             first_time_reg;
    logic [TIME_W-1:0]             second_time_reg;
    logic [TIME_W-1:0]             third_time_reg;

    // end-of-capture working values
    logic                   valid_reg;
    logic [TIME_W-1:0]      per_reg;
    logic [TIME_W-1:0]      high_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [TIME_W-1:0]      freq_reg;
    logic [DUTY_W-1:0]      duty_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] max_out_reg;
    logic [SAMPLE_BITS-1:0] avg_out_reg;
    logic [TIME_W-1:0]      period_out_reg;
    logic [TIME_W-1:0]      freq_out_reg;
    logic [DUTY_W-1:0]      duty_out_reg;
    logic                   pulse_valid_out_reg;

    // divider hookup
    logic                   div_start;
    logic [DIV_N_W-1:0]     div_dividend;
    logic [DIV_D_W-1:0]     div_divisor;
    logic [DIV_N_W-1:0]     div_quot;
    pcs_div_status_t        div_stat;

    // sample decode
    logic signed [SAMPLE_BITS-1:0] s_power;
    logic [TIME_W-1:0]             s_time;
    logic                          s_accept;
    logic                          cnt_room;
    logic                          cnt_nz;
    logic                          s_high;
    logic                          want_high;

    // end-of-capture decode
    logic                   sum_neg;
    logic [SUM_W-1:0]       sum_mag;
    logic [TIME_W-1:0]      per_calc;
    logic [TIME_W-1:0]      high_calc;
    logic                   valid_calc;
    logic                   avg_done;
    logic [SAMPLE_BITS-1:0] avg_calc;
    logic                   out_load;

    assign s_power  = s_tdata[SAMPLE_BITS-1:0];
    assign s_time   = s_tdata[SAMPLE_BITS +: TIME_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cnt_room = sample_count_reg < CNT_W'(MAX_SAMPLES);
    assign cnt_nz   = sample_count_reg != '0;
    assign s_high   = s_power > 0;
    // stage 1 waits for the start level, stages 0 and 2 for the opposite one
    assign want_high = (edge_stage_reg == 2'd1) ? start_high_reg : !start_high_reg;

    // magnitude of the sum for an unsigned divide, sign restored afterwards
    assign sum_neg  = running_sum_reg[SUM_W-1];
    assign sum_mag  = sum_neg ? (~running_sum_reg + 1'b1) : running_sum_reg;
    assign avg_calc = sum_neg ? (~div_quot[SAMPLE_BITS-1:0] + 1'b1)
                              : div_quot[SAMPLE_BITS-1:0];

    // period and high time, high time clamped to the period
    always_comb begin
        per_calc  = third_time_reg - first_time_reg;
        high_calc = start_high_reg ? (third_time_reg - second_time_reg)
                                   : (second_time_reg - first_time_reg);
        if (high_calc > per_calc) begin
            high_calc = per_calc;
        end
        valid_calc = pulse_mode_reg && (edge_stage_reg == 2'd3) && (per_calc != '0);
    end

    // an empty capture skips the average divide
    assign avg_done = !cnt_nz || div_stat.done;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // divider requests, one per sequencer step
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            S_PREP: begin
                div_start    = cnt_nz;
                div_dividend = DIV_N_W'(sum_mag);
                div_divisor  = DIV_D_W'(sample_count_reg);
            end
            S_AVG: begin
                div_start    = avg_done && valid_reg;
                div_dividend = DIV_N_W'(ticks_reg);
                div_divisor  = DIV_D_W'(per_reg);
            end
            S_FREQ: begin
                div_start    = div_stat.done;
                div_dividend = DIV_N_W'(prod_reg);
                div_divisor  = DIV_D_W'(per_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pcs_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .status   (div_stat)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_mode_reg <= PULSE_MODE_RESET;
            ticks_reg      <= TICKS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PULSE_MODE: pulse_mode_reg <= cfg_wdata[0];
                REG_TICKS:      ticks_reg      <= cfg_wdata[TIME_W-1:0];
                default:        pulse_mode_reg <= pulse_mode_reg;
            endcase
        end
    end

    // sequencer, capture state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_tvalid_reg     <= 1'b0;
            running_max_reg  <= {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
            running_sum_reg  <= '0;
            sample_count_reg <= '0;
            start_high_reg   <= 1'b0;
            edge_stage_reg   <= '0;
            first_time_reg   <= '0;
            second_time_reg  <= '0;
            third_time_reg   <= '0;
        end else begin
            // a transfer that is replaced by a new result in the same cycle is reloaded below
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (cnt_room) begin
                            if (!cnt_nz) begin
                                start_high_reg <= s_high;
                            end else if (edge_stage_reg != 2'd3 && s_high == want_high) begin
                                case (edge_stage_reg)
                                    2'd0:    first_time_reg  <= s_time;
                                    2'd1:    second_time_reg <= s_time;
                                    default: third_time_reg  <= s_time;
                                endcase
                                edge_stage_reg <= edge_stage_reg + 1'b1;
                            end
                            if (s_power > running_max_reg) begin
                                running_max_reg <= s_power;
                            end
                            running_sum_reg  <= running_sum_reg
                                + {{CNT_W{s_power[SAMPLE_BITS-1]}}, s_power};
                            sample_count_reg <= sample_count_reg + 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    valid_reg <= valid_calc;
                    per_reg   <= valid_calc ? per_calc : '0;
                    high_reg  <= high_calc;
                    freq_reg  <= '0;
                    duty_reg  <= '0;
                    avg_reg   <= '0;
                    state_reg <= S_AVG;
                end
                S_AVG: begin
                    prod_reg <= high_reg * DUTY_SCALE;
                    if (avg_done) begin
                        if (cnt_nz) begin
                            avg_reg <= avg_calc;
                        end
                        state_reg <= valid_reg ? S_FREQ : S_DONE;
                    end
                end
                S_FREQ: begin
                    if (div_stat.done) begin
                        freq_reg  <= div_quot[TIME_W-1:0];
                        state_reg <= S_DUTY;
                    end
                end
                S_DUTY: begin
                    if (div_stat.done) begin
                        duty_reg  <= div_quot[DUTY_W-1:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        m_tvalid_reg        <= 1'b1;
                        max_out_reg         <= running_max_reg;
                        avg_out_reg         <= avg_reg;
                        period_out_reg      <= per_reg;
                        freq_out_reg        <= freq_reg;
                        duty_out_reg        <= duty_reg;
                        pulse_valid_out_reg <= valid_reg;
                        // clear the capture for the next run
                        running_max_reg     <= {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
                        running_sum_reg     <= '0;
                        sample_count_reg    <= '0;
                        start_high_reg      <= 1'b0;
                        edge_stage_reg      <= '0;
                        first_time_reg      <= '0;
                        second_time_reg     <= '0;
                        third_time_reg      <= '0;
                        state_reg           <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, duty_out_reg, freq_out_reg, period_out_reg,
                       avg_out_reg, max_out_reg};
    assign m_tuser  = pulse_valid_out_reg;

    // counted sample advances the count by one
    `PCS_ASSERT_NEXT(a_count_step, s_accept && cnt_room && !s_tlast, sample_count_reg == $past(sample_count_reg) + 1'b1)
    // closing transfer stalls the input while the divides run
    `PCS_ASSERT_NEXT(a_busy_after_last, s_accept && s_tlast, !s_tready)
    // a valid pulse result has a nonzero period and duty within range
    `PCS_ASSERT_IMPL(a_valid_result, m_tvalid_reg && pulse_valid_out_reg, period_out_reg != '0 && duty_out_reg <= DUTY_SCALE)
    // loading a result leaves an empty capture behind
    `PCS_ASSERT_NEXT(a_clear_after_load, out_load, sample_count_reg == '0 && edge_stage_reg == '0)
    // the divider is never restarted mid-divide
    `PCS_ASSERT_IMPL(a_no_div_overlap, div_start, !div_stat.busy)

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pulse capture stats unit
// ----------------------------------------------------------------------------
// A short table of hand-built captures runs first: single samples at both
// extremes, pulse trains starting low and high, a timestamp wrap, too few
// level changes, a clamped high time, a zero period and a negative average.
// Random captures follow under several register settings. Most of them are
// well-formed pulse trains with random levels and spacing, the rest are raw
// noise. Random captures are checked against a local model of the unit,
// table rows against typed-in results, the stream field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import pcs_pkg::*;

    localparam int SMP_W         = 24;
    localparam int CAPTURE_LIMIT = 65536;
    localparam int S_DATA_W      = ((SMP_W + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W      = ((2 * SMP_W + 2 * TIME_W + DUTY_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 1000000;
    // closing a capture runs up to three serial divisions
    localparam int DRAIN_CYCLES  = 200;

    // bit offsets of the result fields in m_tdata
    localparam int AVG_LSB  = SMP_W;
    localparam int PER_LSB  = 2 * SMP_W;
    localparam int FREQ_LSB = 2 * SMP_W + TIME_W;
    localparam int DUTY_LSB = 2 * SMP_W + 2 * TIME_W;

    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic signed [SMP_W-1:0] SMP_MAX = ~SMP_MIN;

    typedef struct packed {
        logic signed [SMP_W-1:0]  max_p;
        logic signed [SMP_W-1:0]  avg_p;
        logic [TIME_W-1:0]        period;
        logic [TIME_W-1:0]        freq;
        logic [DUTY_W-1:0]        duty;
        logic                     valid;
    } pulse_stats_t;

    typedef struct {
        logic signed [SMP_W-1:0]  power;
        logic [TIME_W-1:0]        stamp;
        bit                       last;
        pulse_stats_t             stats;
    } sample_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;

    pulse_capture_stats_unit #(
        .SAMPLE_BITS(SMP_W),
        .MAX_SAMPLES(CAPTURE_LIMIT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // local copy of the registers
    bit                        mode_pulse;
    logic [TIME_W-1:0]         ticks_sec;

    // local copy of the capture state
    logic signed [SMP_W-1:0]   cap_max;
    longint                    cap_sum;
    int unsigned               cap_count;
    bit                        cap_start_high;
    int                        cap_changes;
    logic [TIME_W-1:0]         change_t1;
    logic [TIME_W-1:0]         change_t2;
    logic [TIME_W-1:0]         change_t3;

    pulse_stats_t              stats_q[$];
    sample_row_t               corner_rows[$];
    pulse_stats_t              no_stats;
    logic [TIME_W-1:0]         stamp_now;
    bit                        idle_on;
    int                        fail_count;
    int                        cycle_count;
    int                        stall_left;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void wipe_capture();
        cap_max        = SMP_MIN;
        cap_sum        = 0;
        cap_count      = 0;
        cap_start_high = 1'b0;
        cap_changes    = 0;
        change_t1      = '0;
        change_t2      = '0;
        change_t3      = '0;
    endfunction

    // fold one accepted sample into the capture; on a closing sample
    // produce the statistics and start a fresh capture
    function automatic void fold_sample(input logic signed [SMP_W-1:0] p,
                                        input logic [TIME_W-1:0] t, input bit last,
                                        output bit closed, output pulse_stats_t r);
        bit                 hi;
        bit                 want;
        logic [TIME_W-1:0]  per;
        logic [TIME_W-1:0]  high_t;
        longint unsigned    scaled;
        closed = 1'b0;
        r      = '0;
        if (cap_count < CAPTURE_LIMIT) begin
            hi = (p > 0);
            if (cap_count == 0) begin
                cap_start_high = hi;
            end else if (cap_changes < 3) begin
                // first and third change go to the opposite level, second back
                want = (cap_changes == 1) ? cap_start_high : !cap_start_high;
                if (hi == want) begin
                    case (cap_changes)
                        0:       change_t1 = t;
                        1:       change_t2 = t;
                        default: change_t3 = t;
                    endcase
                    cap_changes++;
                end
            end
            if (p > cap_max) cap_max = p;
            cap_sum += p;
            cap_count++;
        end
        if (last) begin
            closed  = 1'b1;
            r.max_p = cap_max;
            if (cap_count != 0) r.avg_p = SMP_W'(cap_sum / longint'(cap_count));
            if (mode_pulse && cap_changes == 3) begin
                per = change_t3 - change_t1;
                if (per != 0) begin
                    high_t = cap_start_high ? change_t3 - change_t2 : change_t2 - change_t1;
                    if (high_t > per) high_t = per;
                    scaled   = 64'(high_t) * DUTY_SCALE / per;
                    r.period = per;
                    r.freq   = ticks_sec / per;
                    r.duty   = DUTY_W'(scaled);
                    r.valid  = 1'b1;
                end
            end
            wipe_capture();
        end
    endfunction

    function automatic void add_row(input logic signed [SMP_W-1:0] p,
                                    input logic [TIME_W-1:0] t);
        sample_row_t row;
        row.power = p;
        row.stamp = t;
        row.last  = 1'b0;
        row.stats = '0;
        corner_rows.push_back(row);
    endfunction

    // closing sample with its result typed in
    function automatic void add_close(input logic signed [SMP_W-1:0] p,
                                      input logic [TIME_W-1:0] t,
                                      input logic signed [SMP_W-1:0] e_max,
                                      input logic signed [SMP_W-1:0] e_avg,
                                      input logic [TIME_W-1:0] e_per,
                                      input logic [TIME_W-1:0] e_freq,
                                      input logic [DUTY_W-1:0] e_duty, input bit e_valid);
        sample_row_t row;
        row.power = p;
        row.stamp = t;
        row.last  = 1'b1;
        row.stats = '{e_max, e_avg, e_per, e_freq, e_duty, e_valid};
        corner_rows.push_back(row);
    endfunction

    // random sample of a given level: zero counts as low
    function automatic logic signed [SMP_W-1:0] level_sample(input bit hi);
        int mag;
        case ($urandom_range(0, 7))
            0:       mag = int'(SMP_MAX);
            1, 2, 3: mag = $urandom_range(1, 255);
            default: mag = $urandom_range(1, int'(SMP_MAX));
        endcase
        if (hi) return SMP_W'(mag);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SMP_MIN;
            default: return SMP_W'(-mag);
        endcase
    endfunction

    // one input transfer, optionally after a random gap; valid stays high
    // afterwards so back-to-back transfers need no toggle
    task automatic push_sample(input logic signed [SMP_W-1:0] p, input logic [TIME_W-1:0] t,
                               input bit last, input bit typed, input pulse_stats_t typed_stats);
        bit           closed;
        pulse_stats_t r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({t, p});
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        fold_sample(p, t, last, closed, r);
        if (closed) stats_q.push_back(typed ? typed_stats : r);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results();
        while (stats_q.size() != 0) @(posedge aclk);
    endtask

    // quiet point: input stopped, results drained, closing divisions done
    task automatic settle();
        drop_valid();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_PULSE_MODE) mode_pulse = val[0];
        else                       ticks_sec  = val;
    endtask

    // random captures until about item_goal samples went in; most are
    // pulse trains with random run lengths, the rest raw noise
    task automatic run_random(input int item_goal);
        int                       sent;
        int                       n;
        int                       run;
        bit                       well;
        bit                       level;
        logic signed [SMP_W-1:0]  p;
        sent = 0;
        while (sent < item_goal) begin
            n     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            well  = ($urandom_range(0, 9) < 8);
            level = $urandom_range(0, 1);
            run   = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (well) begin
                    if (run == 0) begin
                        level = !level;
                        run   = $urandom_range(1, 4);
                    end
                    run--;
                    p = level_sample(level);
                    // mostly short spacing, now and then a jump that may wrap
                    stamp_now += ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32'h7fff_ffff)
                                                             : $urandom_range(1, 2000);
                end else begin
                    p = SMP_W'($urandom);
                    if ($urandom_range(0, 3) == 0) stamp_now = $urandom;
                    else                           stamp_now += $urandom_range(0, 2000);
                end
                push_sample(p, stamp_now, i == n - 1, 1'b0, no_stats);
            end
            sent += n;
            // sometimes hold the input until the result stream is empty
            if ($urandom_range(0, 7) == 0) begin
                drop_valid();
                wait_results();
            end
        end
    endtask

    // result receiver: random stall bursts while idling is on
    always @(negedge aclk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 4);
        if (idle_on && stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        pulse_stats_t want;
        pulse_stats_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.max_p  = m_tdata[SMP_W-1:0];
            seen.avg_p  = m_tdata[AVG_LSB +: SMP_W];
            seen.period = m_tdata[PER_LSB +: TIME_W];
            seen.freq   = m_tdata[FREQ_LSB +: TIME_W];
            seen.duty   = m_tdata[DUTY_LSB +: DUTY_W];
            seen.valid  = m_tuser[0];
            if (stats_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = stats_q.pop_front();
                if (seen.max_p !== want.max_p) begin
                    $error("max_power expected %0d got %0d", want.max_p, seen.max_p);
                    fail_count++;
                end
                if (seen.avg_p !== want.avg_p) begin
                    $error("avg_power expected %0d got %0d", want.avg_p, seen.avg_p);
                    fail_count++;
                end
                if (seen.period !== want.period) begin
                    $error("period_ticks expected %0d got %0d", want.period, seen.period);
                    fail_count++;
                end
                if (seen.freq !== want.freq) begin
                    $error("freq_hz expected %0d got %0d", want.freq, seen.freq);
                    fail_count++;
                end
                if (seen.duty !== want.duty) begin
                    $error("duty_q8 expected %0d got %0d", want.duty, seen.duty);
                    fail_count++;
                end
                if (seen.valid !== want.valid) begin
                    $error("pulse_valid expected %0d got %0d", want.valid, seen.valid);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b1;
        idle_on     = 1'b1;
        fail_count  = 0;
        cycle_count = 0;
        stall_left  = 0;
        no_stats    = '0;
        mode_pulse  = PULSE_MODE_RESET;
        ticks_sec   = TICKS_RESET;
        wipe_capture();

        // single samples at both extremes: no changes, so no pulse
        add_close(SMP_MAX, 32'd0, SMP_MAX, SMP_MAX, 0, 0, 0, 1'b0);
        add_close(SMP_MIN, 32'hffff_ffff, SMP_MIN, SMP_MIN, 0, 0, 0, 1'b0);
        // starting low, changes at 200, 450, 600
        add_row(-5, 32'd100);
        add_row(10, 32'd200);
        add_row(20, 32'd300);
        add_row(-1, 32'd450);
        add_row(7, 32'd600);
        add_close(3, 32'd700, 20, 5, 32'd400, 32'd2500, 15'd16000, 1'b1);
        // starting high, zero counts as low, timestamps wrap through zero
        add_row(100, 32'hffff_ff00);
        add_row(0, 32'hffff_fff0);
        add_row(50, 32'h0000_0010);
        add_close(-50, 32'h0000_0030, 100, 25, 32'd64, 32'd15625, 15'd12800, 1'b1);
        // only two changes
        add_row(5, 32'd10);
        add_row(-5, 32'd20);
        add_close(5, 32'd30, 5, 1, 0, 0, 0, 1'b0);
        // timestamps going backward: high time clamped to the period
        add_row(-1, 32'd1000);
        add_row(1, 32'd500);
        add_row(-1, 32'd2000);
        add_close(1, 32'd600, 1, 0, 32'd100, 32'd10000, 15'd25600, 1'b1);
        // first and third change at the same time: zero period
        add_row(-1, 32'd5);
        add_row(1, 32'd7);
        add_row(-1, 32'd9);
        add_close(1, 32'd7, 1, 0, 0, 0, 0, 1'b0);
        // negative average truncates toward zero
        add_row(-7, 32'd1);
        add_close(-2, 32'd2, -2, -4, 0, 0, 0, 1'b0);

        // reset released on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // corner table under the reset register values
        foreach (corner_rows[i])
            push_sample(corner_rows[i].power, corner_rows[i].stamp, corner_rows[i].last,
                        corner_rows[i].last, corner_rows[i].stats);
        settle();

        // continuous mode with the smallest nonzero tick rate
        stamp_now = $urandom;
        write_reg(REG_PULSE_MODE, 32'd0);
        write_reg(REG_TICKS, 32'd1);
        run_random(200);
        settle();

        // pulse mode, zero tick rate gives zero frequency
        write_reg(REG_PULSE_MODE, 32'd1);
        write_reg(REG_TICKS, 32'd0);
        run_random(200);
        settle();

        // largest tick rate
        write_reg(REG_TICKS, 32'hffff_ffff);
        run_random(200);
        settle();

        write_reg(REG_TICKS, $urandom);
        run_random(200);
        settle();

        // last stretch without any idling on either side
        idle_on = 1'b0;
        write_reg(REG_TICKS, $urandom_range(1, 1000000));
        run_random(200);
        settle();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
